>>> hw/rtl/qed_pkg.sv
package qed_pkg;

    // characters the decoder looks for
    localparam logic [7:0] CH_EQUALS     = 8'h3D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;

    // most bytes one input transfer can produce
    localparam int unsigned RES_DEPTH = 3;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_EQ    = 2'd1,
        PH_DIGIT = 2'd2
    } t_phase;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // result bundle from the step logic to the result buffer
    typedef struct packed {
        logic [1:0]                count;
        logic [RES_DEPTH-1:0][7:0] bytes;
        logic [RES_DEPTH-1:0]      lasts;
    } t_step_out;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b0;
        h.val = 4'd0;
        if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) begin
            h.ok  = 1'b1;
            h.val = 4'(c - CH_ZERO);
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd5) begin
            h.ok  = 1'b1;
            h.val = 4'(c - CH_LOWER_A + 8'd10);
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5) begin
            h.ok  = 1'b1;
            h.val = 4'(c - CH_UPPER_A + 8'd10);
        end
        return h;
    endfunction

endpackage

>>> hw/rtl/qed_if.sv
interface qed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface qed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

>>> hw/rtl/qed_step.sv
module qed_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    output qed_pkg::t_step_out  o_res
);

    qed_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_held, n_held;

    qed_pkg::t_hex   hx;
    qed_pkg::t_hex   hh;
    logic [1:0]      pre;
    logic            direct;
    logic            hold;
    logic            norm_emit;
    logic [7:0]      norm_byte;

    always_comb begin
        hx        = qed_pkg::hex_decode(i_byte);
        hh        = qed_pkg::hex_decode(r_held);
        n_phase   = qed_pkg::PH_IDLE;
        n_held    = r_held;
        pre       = 2'd0;
        direct    = 1'b0;
        hold      = 1'b0;
        norm_emit = 1'b0;
        norm_byte = i_byte;

        case (r_phase)
            qed_pkg::PH_DIGIT: begin
                if (hx.ok && hh.ok) begin
                    direct = 1'b1;
                end else begin
                    pre = 2'd2;
                end
            end
            qed_pkg::PH_EQ: begin
                // a hex digit extends the escape unless the string ends here
                if (hx.ok && !i_last) begin
                    hold    = 1'b1;
                    n_phase = qed_pkg::PH_DIGIT;
                    n_held  = i_byte;
                end else begin
                    pre = 2'd1;
                end
            end
            default: begin
            end
        endcase

        if (!direct && !hold) begin
            if (i_byte == qed_pkg::CH_EQUALS) begin
                if (i_last) begin
                    norm_emit = 1'b1;
                end else begin
                    n_phase = qed_pkg::PH_EQ;
                end
            end else if (i_byte == qed_pkg::CH_UNDERSCORE) begin
                norm_emit = 1'b1;
                norm_byte = qed_pkg::CH_SPACE;
            end else begin
                norm_emit = 1'b1;
            end
        end

        o_res.bytes = '0;
        o_res.lasts = '0;
        if (direct) begin
            o_res.count    = 2'd1;
            o_res.bytes[0] = {hh.val, hx.val};
            o_res.lasts[0] = i_last;
        end else begin
            o_res.count = 2'(pre + {1'b0, norm_emit});
            case (pre)
                2'd1: begin
                    o_res.bytes[0] = qed_pkg::CH_EQUALS;
                    o_res.bytes[1] = norm_byte;
                    o_res.lasts[1] = i_last & norm_emit;
                end
                2'd2: begin
                    o_res.bytes[0] = qed_pkg::CH_EQUALS;
                    o_res.bytes[1] = r_held;
                    o_res.bytes[2] = norm_byte;
                    o_res.lasts[2] = i_last & norm_emit;
                end
                default: begin
                    o_res.bytes[0] = norm_byte;
                    o_res.lasts[0] = i_last & norm_emit;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= qed_pkg::PH_IDLE;
        end else if (i_take) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_held <= n_held;
        end
    end

endmodule

>>> hw/rtl/qed_result_buf.sv
module qed_result_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  qed_pkg::t_step_out i_res,
    input  logic               i_out_ready,
    output logic               o_free,
    output logic               o_out_valid,
    output logic [7:0]         o_out_byte,
    output logic               o_out_last
);

    logic [1:0]                         r_cnt, n_cnt;
    logic [1:0]                         r_head, n_head;
    logic [qed_pkg::RES_DEPTH-1:0][7:0] r_bytes;
    logic [qed_pkg::RES_DEPTH-1:0]      r_lasts;
    logic                               pop;

    assign o_out_valid = (r_cnt != 2'd0);
    assign pop         = o_out_valid && i_out_ready;
    // empty after this cycle's transfer, so a new bundle may land
    assign o_free      = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_out_ready);
    assign o_out_byte  = r_bytes[r_head];
    assign o_out_last  = r_lasts[r_head];

    always_comb begin
        n_cnt  = r_cnt;
        n_head = r_head;
        if (i_load) begin
            n_cnt  = i_res.count;
            n_head = 2'd0;
        end else if (pop) begin
            n_cnt  = r_cnt - 2'd1;
            n_head = r_head + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_head <= 2'd0;
        end else begin
            r_cnt  <= n_cnt;
            r_head <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_res.bytes;
            r_lasts <= i_res.lasts;
        end
    end

endmodule

>>> hw/rtl/q_encoding_byte_decoder.sv
// Q-encoding (quoted-printable) byte decoder. Takes one encoded byte per transfer on i_in
// and delivers decoded bytes on o_out: "=XX" (hex, either case) becomes one byte, "_"
// becomes a space, everything else passes. A broken escape releases the held "=" and digit
// literally before the breaking byte; in_last flushes anything held and tags the final
// decoded byte with out_last. Input is registered, decoded combinationally into a three-entry
// result buffer, and drained one byte per cycle while o_out is ready. The sustained rate is
// one input byte per cycle while the output is ready, except that a transfer yielding N > 1
// bytes (N up to 3) holds off the next transfer until the one-byte output port has drained them.
module q_encoding_byte_decoder (
    input  logic             i_clk,
    input  logic             i_rst_n,
    qed_in_if.sink           i_in,
    qed_out_if.source        o_out
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_last;
    logic               buf_free;
    logic               take;
    qed_pkg::t_step_out res;

    assign take       = r_in_valid && buf_free;
    assign i_in.ready = !r_in_valid || buf_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
            r_in_last <= i_in.in_last;
        end
    end

    qed_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_res   (res)
    );

    qed_result_buf u_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (take),
        .i_res       (res),
        .i_out_ready (o_out.ready),
        .o_free      (buf_free),
        .o_out_valid (o_out.valid),
        .o_out_byte  (o_out.out_byte),
        .o_out_last  (o_out.out_last)
    );

endmodule

>>> hw/rtl/qed_checker.sv
module qed_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // with the result side empty the input can never be blocked
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while no result pending");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped during stall");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_byte) && $stable(i_out_last))
        else $error("output payload changed during stall");

endmodule

bind q_encoding_byte_decoder qed_checker u_qed_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.out_last)
);

>>> sim/tb_q_encoding_byte_decoder.sv
module tb_q_encoding_byte_decoder;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int RAND_ITEMS  = 155;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_dec_byte;

    // decoded-byte predictor plus in-order checker
    class qed_scoreboard;
        t_dec_byte       expected_q[$];
        qed_pkg::t_phase phase;
        logic [7:0]      held_char;
        int              errors;
        int              n_inputs;
        int              n_results;
        int              n_escapes;

        function new();
            phase     = qed_pkg::PH_IDLE;
            held_char = 8'h00;
            errors    = 0;
            n_inputs  = 0;
            n_results = 0;
            n_escapes = 0;
        endfunction

        function bit is_hex(logic [7:0] c);
            return (c >= qed_pkg::CH_ZERO && c <= qed_pkg::CH_ZERO + 8'd9) ||
                   (c >= qed_pkg::CH_LOWER_A && c <= qed_pkg::CH_LOWER_A + 8'd5) ||
                   (c >= qed_pkg::CH_UPPER_A && c <= qed_pkg::CH_UPPER_A + 8'd5);
        endfunction

        function logic [3:0] nibble_of(logic [7:0] c);
            if (c <= qed_pkg::CH_ZERO + 8'd9)
                return 4'(c - qed_pkg::CH_ZERO);
            else if (c >= qed_pkg::CH_LOWER_A)
                return 4'(c - qed_pkg::CH_LOWER_A + 8'd10);
            else
                return 4'(c - qed_pkg::CH_UPPER_A + 8'd10);
        endfunction

        function void push_byte(logic [7:0] d, logic l);
            t_dec_byte e;
            e.data = d;
            e.last = l;
            expected_q.push_back(e);
        endfunction

        function void note_input(logic [7:0] b, logic l);
            bit plain;
            plain = 1'b1;
            n_inputs++;
            case (phase)
                qed_pkg::PH_DIGIT: begin
                    if (is_hex(b) && is_hex(held_char)) begin
                        push_byte({nibble_of(held_char), nibble_of(b)}, l);
                        n_escapes++;
                        plain = 1'b0;
                    end else begin
                        push_byte(qed_pkg::CH_EQUALS, 1'b0);
                        push_byte(held_char, 1'b0);
                    end
                    phase = qed_pkg::PH_IDLE;
                end
                qed_pkg::PH_EQ: begin
                    if (is_hex(b)) begin
                        if (l) begin
                            // flush: '=' and the digit go out literally
                            push_byte(qed_pkg::CH_EQUALS, 1'b0);
                            push_byte(b, 1'b1);
                            phase = qed_pkg::PH_IDLE;
                        end else begin
                            held_char = b;
                            phase     = qed_pkg::PH_DIGIT;
                        end
                        plain = 1'b0;
                    end else begin
                        push_byte(qed_pkg::CH_EQUALS, 1'b0);
                        phase = qed_pkg::PH_IDLE;
                    end
                end
                default: phase = qed_pkg::PH_IDLE;
            endcase
            if (plain) begin
                if (b == qed_pkg::CH_EQUALS) begin
                    if (l)
                        push_byte(qed_pkg::CH_EQUALS, 1'b1);
                    else
                        phase = qed_pkg::PH_EQ;
                end else if (b == qed_pkg::CH_UNDERSCORE) begin
                    push_byte(qed_pkg::CH_SPACE, l);
                end else begin
                    push_byte(b, l);
                end
            end
        endfunction

        function void check_result(logic [7:0] d, logic l);
            t_dec_byte e;
            n_results++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected output byte %h last %b", $time, d, l);
                return;
            end
            e = expected_q.pop_front();
            if (e.data !== d) begin
                errors++;
                $display("%0t: out_byte mismatch, expected %h actual %h", $time, e.data, d);
            end
            if (e.last !== l) begin
                errors++;
                $display("%0t: out_last mismatch, expected %b actual %b", $time, e.last, l);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic hold_req;
    bit   fast_mode;
    int   n_holds;
    int   cycles = 0;

    qed_scoreboard sb = new();

    qed_in_if  in_if();
    qed_out_if out_if();

    q_encoding_byte_decoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still expected", cycles, sb.pending());
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic rand_last();
        return ($urandom_range(0, 11) == 0);
    endfunction

    function automatic logic [7:0] rand_hex();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
            return qed_pkg::CH_ZERO + 8'(v);
        else if ($urandom_range(0, 1))
            return qed_pkg::CH_UPPER_A + 8'(v - 10);
        else
            return qed_pkg::CH_LOWER_A + 8'(v - 10);
    endfunction

    // characters on either side of each hex range
    function automatic logic [7:0] border_char();
        case ($urandom_range(0, 11))
            0:       return qed_pkg::CH_ZERO - 8'd1;
            1:       return qed_pkg::CH_ZERO;
            2:       return qed_pkg::CH_ZERO + 8'd9;
            3:       return qed_pkg::CH_ZERO + 8'd10;
            4:       return qed_pkg::CH_UPPER_A - 8'd1;
            5:       return qed_pkg::CH_UPPER_A;
            6:       return qed_pkg::CH_UPPER_A + 8'd5;
            7:       return qed_pkg::CH_UPPER_A + 8'd6;
            8:       return qed_pkg::CH_LOWER_A - 8'd1;
            9:       return qed_pkg::CH_LOWER_A;
            10:      return qed_pkg::CH_LOWER_A + 8'd5;
            default: return qed_pkg::CH_LOWER_A + 8'd6;
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        gap = fast_mode ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.in_byte = b;
        in_if.in_last = l;
        in_if.valid   = 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_input(b, l);
        @(negedge i_clk);
    endtask

    task automatic send_token();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            send_byte(qed_pkg::CH_EQUALS, rand_last());
            send_byte(rand_hex(), rand_last());
            send_byte(rand_hex(), rand_last());
        end else if (r < 60) begin
            send_byte(8'($urandom_range(0, 255)), rand_last());
        end else if (r < 70) begin
            send_byte(qed_pkg::CH_UNDERSCORE, rand_last());
        end else if (r < 80) begin
            send_byte(qed_pkg::CH_EQUALS, rand_last());
            send_byte(8'($urandom_range(0, 255)), rand_last());
        end else if (r < 90) begin
            send_byte(qed_pkg::CH_EQUALS, rand_last());
            send_byte(rand_hex(), rand_last());
            send_byte(8'($urandom_range(0, 255)), rand_last());
        end else begin
            send_byte(qed_pkg::CH_EQUALS, rand_last());
            send_byte(border_char(), rand_last());
            send_byte(border_char(), rand_last());
        end
    endtask

    // output side
    initial begin
        int gap;
        out_if.ready = 1'b0;
        n_holds      = 0;
        @(negedge i_clk);
        while (i_rst_n !== 1'b1) @(negedge i_clk);
        forever begin
            if (hold_req) begin
                out_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
                n_holds++;
            end
            gap = fast_mode ? 0 : $urandom_range(0, 7);
            if (gap != 0) begin
                out_if.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_if.ready = 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            sb.check_result(out_if.out_byte, out_if.out_last);
            @(negedge i_clk);
        end
    end

    initial begin
        bit held_off;
        bit drained;
        int k;
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.in_byte = 8'h00;
        in_if.in_last = 1'b0;
        hold_req      = 1'b0;
        fast_mode     = 1'b0;
        held_off      = 1'b0;
        drained       = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // plain bytes, underscore, field extremes
        send_byte("A", 1'b0);
        send_byte(qed_pkg::CH_UNDERSCORE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        // good escapes, both cases
        send_byte(qed_pkg::CH_EQUALS, 1'b0);
        send_byte("4", 1'b0);
        send_byte("a", 1'b0);
        send_byte(qed_pkg::CH_EQUALS, 1'b0);
        send_byte("F", 1'b0);
        send_byte("0", 1'b0);
        // broken right after '='
        send_byte(qed_pkg::CH_EQUALS, 1'b0);
        send_byte("x", 1'b0);
        // breaking byte opens a new escape
        send_byte(qed_pkg::CH_EQUALS, 1'b0);
        send_byte(qed_pkg::CH_EQUALS, 1'b0);
        send_byte("9", 1'b0);
        send_byte("B", 1'b0);
        // broken after one digit
        send_byte(qed_pkg::CH_EQUALS, 1'b0);
        send_byte("c", 1'b0);
        send_byte("g", 1'b0);
        // last byte with '=' and a digit held: three bytes out
        send_byte(qed_pkg::CH_EQUALS, 1'b0);
        send_byte("7", 1'b0);
        send_byte("Z", 1'b1);
        // lone '=' marked last
        send_byte(qed_pkg::CH_EQUALS, 1'b1);
        // last on the first digit
        send_byte(qed_pkg::CH_EQUALS, 1'b0);
        send_byte("e", 1'b1);

        k = sb.n_inputs;
        while (sb.n_inputs - k < RAND_ITEMS) begin
            if ($urandom_range(0, 15) == 0)
                fast_mode = ~fast_mode;
            if (!held_off && sb.n_inputs - k >= 60) begin
                // stall the output long enough to back up the input
                held_off  = 1'b1;
                fast_mode = 1'b1;
                hold_req  = 1'b1;
                repeat (8) send_token();
                fast_mode = 1'b0;
            end else if (!drained && sb.n_inputs - k >= 120) begin
                drained = 1'b1;
                in_if.valid = 1'b0;
                while (sb.pending() != 0) @(negedge i_clk);
            end else begin
                send_token();
            end
        end
        in_if.valid = 1'b0;
        fast_mode   = 1'b0;

        while (sb.pending() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        $display("%0d encoded bytes in, %0d decoded bytes out, %0d good escapes",
                 sb.n_inputs, sb.n_results, sb.n_escapes);
        $display("%0d long output stalls, %0d mismatches", n_holds, sb.errors);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/qed_pkg.sv
hw/rtl/qed_if.sv
hw/rtl/qed_step.sv
hw/rtl/qed_result_buf.sv
hw/rtl/q_encoding_byte_decoder.sv
hw/rtl/qed_checker.sv
sim/tb_q_encoding_byte_decoder.sv
